@@ rtl/core/pbts_pkg.sv @@
// Shared constants and request codes for the priority bitmap task scheduler.
// No dependencies; every other file in rtl/core imports this package.
package pbts_pkg;

	// One task for each priority; a lower number is a higher priority.
	localparam int NUM_PRIOS  = 32;
	localparam int PRIO_BITS  = 5;
	localparam int DELAY_BITS = 32;

	// Field widths fixed by the interface.
	localparam int REQ_W   = 2;
	localparam int TASK_W  = 5;
	localparam int DTICK_W = 32;
	localparam int LOCK_W  = 8;

	// Largest counter value that the delay store can hold.
	localparam logic [DTICK_W-1:0] DELAY_MAX = DTICK_W'({DELAY_BITS{1'b1}});

	// Request codes carried on req_type.
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELAY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READY = 2'd2;

	typedef logic [NUM_PRIOS-1:0]  prio_mask_t;
	typedef logic [PRIO_BITS-1:0]  prio_idx_t;
	typedef logic [DELAY_BITS-1:0] delay_cnt_t;

	// Result of the lowest-set-bit search.
	typedef struct packed {
		logic      any;
		prio_idx_t idx;
	} pick_t;

endpackage

@@ rtl/core/pbts_ffs.sv @@
// Lowest-set-bit search over the ready mask, built as a halving search.
// Depends on pbts_pkg for the mask width and the pick_t result type.
module pbts_ffs (
	input  pbts_pkg::prio_mask_t mask,
	output pbts_pkg::pick_t      pick
);
	import pbts_pkg::*;

	// Each level looks at the lower half of the window and drops it if it is empty.
	always_comb begin
		prio_mask_t win;
		prio_idx_t  idx;
		win = mask;
		idx = '0;
		for (int b = PRIO_BITS - 1; b >= 0; b--) begin
			if ((win << (NUM_PRIOS - (1 << b))) == '0) begin
				idx[b] = 1'b1;
				win    = win >> (1 << b);
			end
		end
		pick.any = |mask;
		pick.idx = idx;
	end

endmodule

@@ rtl/core/priority_bitmap_task_scheduler_unit.sv @@
// Top level of the priority bitmap task scheduler: request FSM, delay counter walk
// and result register. Depends on pbts_pkg and instantiates pbts_ffs.
//
// Usage. Requests arrive as words on the in_valid/in_ready channel: a tick
// (req_type 0), a delay of the running task by delay_ticks (req_type 1) or making
// task task_prio ready (req_type 2). Each request gives exactly one result word on
// out_valid/out_ready: next_task, do_switch and none_ready. The lock count is
// written on the cfg_valid/cfg_ready channel, which is always ready.
// Flow: a delay or ready request goes from acceptance to the scheduling state,
// which loads the result register. A tick first walks the delay counter memory
// one entry a cycle through the single shared decrementer, then drains the last
// write-back and loads the result. in_ready is high only while the sequencer is
// idle, from the cycle after the result is loaded, so a new request is accepted
// only once the previous one has finished its work.
// A finished result is held in the output register while the receiver stalls, and
// the next request may be accepted meanwhile; it waits at the end of its work until
// the register is free. Reset clears the ready and delayed masks, the running task,
// the lock count and the output valid. The counter memory is not cleared, since a
// counter is only used for a task that has been delayed.
module priority_bitmap_task_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pbts_pkg::REQ_W-1:0]    req_type,
	input  logic [pbts_pkg::TASK_W-1:0]   task_prio,
	input  logic [pbts_pkg::DTICK_W-1:0]  delay_ticks,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pbts_pkg::TASK_W-1:0]   next_task,
	output logic                          do_switch,
	output logic                          none_ready,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pbts_pkg::LOCK_W-1:0]   cfg_data
);
	import pbts_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_SCHED = 2'd2;

	localparam int IDX_W = PRIO_BITS + 1;

	logic [1:0]          state_q;
	prio_mask_t          ready_mask_q;
	prio_mask_t          delayed_mask_q;
	prio_idx_t           running_q;
	logic [LOCK_W-1:0]   lock_q;
	logic [IDX_W-1:0]    walk_idx_q;
	logic                walk_vld_s1;
	prio_idx_t           walk_idx_s1;
	delay_cnt_t          rdata_s1;
	delay_cnt_t          cnt_mem [NUM_PRIOS];
	logic                out_valid_q;
	logic [TASK_W-1:0]   next_task_q;
	logic                do_switch_q;
	logic                none_ready_q;

	logic                in_acc;
	logic                walk_issue;
	logic                out_free;
	delay_cnt_t          dec_val;
	delay_cnt_t          delay_sat;
	logic                mem_we;
	prio_idx_t           mem_waddr;
	delay_cnt_t          mem_wdata;
	pick_t               pick;
	logic                prio_ok;
	logic                sw_now;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Walk issues one counter read a cycle until every priority has been visited.
	assign walk_issue = (state_q == ST_WALK) && (walk_idx_q != IDX_W'(NUM_PRIOS));

	// The shared decrementer works on the counter read in the previous cycle.
	assign dec_val = rdata_s1 - 1'b1;

	// A delay of zero waits one tick; a delay beyond the counter range saturates.
	always_comb begin
		if (delay_ticks == '0) begin
			delay_sat = delay_cnt_t'(1);
		end else if (delay_ticks > DELAY_MAX) begin
			delay_sat = delay_cnt_t'(DELAY_MAX);
		end else begin
			delay_sat = delay_cnt_t'(delay_ticks);
		end
	end

	assign prio_ok = {1'b0, task_prio} < (TASK_W + 1)'(NUM_PRIOS);

	// Memory write port: the walk write-back, or a new delay for the running task.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = walk_idx_s1;
		mem_wdata = dec_val;
		if (walk_vld_s1) begin
			mem_we = 1'b1;
		end else if (in_acc && req_type == REQ_DELAY) begin
			mem_we    = 1'b1;
			mem_waddr = running_q;
			mem_wdata = delay_sat;
		end
	end

	// Delay counter memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem[mem_waddr] <= mem_wdata;
		end
		if (walk_issue) begin
			rdata_s1 <= cnt_mem[walk_idx_q[PRIO_BITS-1:0]];
		end
	end

	// Index of the counter in the read stage, carried alongside the read data.
	always_ff @(posedge clk) begin
		if (walk_issue) begin
			walk_idx_s1 <= walk_idx_q[PRIO_BITS-1:0];
		end
	end

	pbts_ffs u_ffs (
		.mask (ready_mask_q),
		.pick (pick)
	);

	assign sw_now = pick.any && (lock_q == '0) && (pick.idx != running_q);

	// Lock count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			lock_q <= cfg_data;
		end
	end

	// Sequencer, masks and running task.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ready_mask_q   <= '0;
			delayed_mask_q <= '0;
			running_q      <= '0;
			walk_idx_q     <= '0;
			walk_vld_s1    <= 1'b0;
		end else begin
			// A counter that reaches zero moves its task to the ready set.
			if (walk_vld_s1 && dec_val == '0) begin
				delayed_mask_q[walk_idx_s1] <= 1'b0;
				ready_mask_q[walk_idx_s1]   <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (req_type)
							REQ_TICK: begin
								walk_idx_q <= '0;
								state_q    <= ST_WALK;
							end
							REQ_DELAY: begin
								delayed_mask_q[running_q] <= 1'b1;
								ready_mask_q[running_q]   <= 1'b0;
								state_q                   <= ST_SCHED;
							end
							REQ_READY: begin
								if (prio_ok) begin
									delayed_mask_q[task_prio[PRIO_BITS-1:0]] <= 1'b0;
									ready_mask_q[task_prio[PRIO_BITS-1:0]]   <= 1'b1;
								end
								state_q <= ST_SCHED;
							end
							default: begin
								state_q <= ST_SCHED;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (walk_issue) begin
						walk_vld_s1 <= delayed_mask_q[walk_idx_q[PRIO_BITS-1:0]];
						walk_idx_q  <= walk_idx_q + 1'b1;
					end else begin
						walk_vld_s1 <= 1'b0;
						state_q     <= ST_SCHED;
					end
				end
				ST_SCHED: begin
					if (out_free) begin
						if (sw_now) begin
							running_q <= pick.idx;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register; it holds its word while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_SCHED && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCHED && out_free) begin
			next_task_q  <= pick.any ? TASK_W'(pick.idx) : TASK_W'(running_q);
			do_switch_q  <= sw_now;
			none_ready_q <= !pick.any;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_task  = next_task_q;
	assign do_switch  = do_switch_q;
	assign none_ready = none_ready_q;

	// A task is never both ready and delayed.
	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_mask_q & delayed_mask_q) == '0)
		else $error("task is both ready and delayed");

	// The counter walk has drained whenever a new word can be accepted.
	a_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !walk_vld_s1)
		else $error("counter walk still busy while idle");

	// A switch is only requested when a task is ready.
	a_switch_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && do_switch) |-> !none_ready)
		else $error("switch requested with no ready task");

	// Loading a switch result moves the running task to the chosen priority.
	a_switch_updates_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCHED && out_free && sw_now) |=>
			(running_q == $past(pick.idx) && do_switch_q))
		else $error("running task not updated on switch");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for priority_bitmap_task_scheduler_unit: directed and random
// request words, each result word checked against a scheduler model kept in this file.
// Depends on pbts_pkg and the scheduler RTL only.
module testbench;
	import pbts_pkg::*;

	// The package names no code for the spare request value.
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = NUM_PRIOS + 8;

	typedef struct packed {
		prio_idx_t pick;
		logic      sw;
		logic      idle;
	} sched_word_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [REQ_W-1:0]    req_type;
	logic [TASK_W-1:0]   task_prio;
	logic [DTICK_W-1:0]  delay_ticks;
	logic                out_valid;
	logic                out_ready;
	logic [TASK_W-1:0]   next_task;
	logic                do_switch;
	logic                none_ready;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LOCK_W-1:0]   cfg_data;

	// Scheduler state as the testbench expects it to be.
	prio_mask_t        ready_set    = '0;
	prio_mask_t        delayed_set  = '0;
	delay_cnt_t        wait_ticks [NUM_PRIOS];
	prio_idx_t         current_task = '0;
	logic [LOCK_W-1:0] lock_level   = '0;

	sched_word_t expected_words [$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          idling_on   = 1'b1;

	priority_bitmap_task_scheduler_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.task_prio   (task_prio),
		.delay_ticks (delay_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.next_task   (next_task),
		.do_switch   (do_switch),
		.none_ready  (none_ready),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request to the expected state and returns the result word it gives.
	function automatic sched_word_t schedule_step(input logic [REQ_W-1:0] req,
			input logic [TASK_W-1:0] prio, input logic [DTICK_W-1:0] dly);
		sched_word_t res;
		delay_cnt_t  load;
		res = '0;
		case (req)
			REQ_TICK: begin
				// Every delayed task counts down; those reaching zero wake up.
				for (int i = 0; i < NUM_PRIOS; i++) begin
					if (delayed_set[i]) begin
						wait_ticks[i] = wait_ticks[i] - 1'b1;
						if (wait_ticks[i] == '0) begin
							delayed_set[i] = 1'b0;
							ready_set[i]   = 1'b1;
						end
					end
				end
			end
			REQ_DELAY: begin
				// A zero delay still waits one tick; an oversized one saturates.
				if (dly == '0)
					load = delay_cnt_t'(1);
				else if (dly > DTICK_W'(DELAY_MAX))
					load = delay_cnt_t'(DELAY_MAX);
				else
					load = delay_cnt_t'(dly);
				wait_ticks[current_task]  = load;
				delayed_set[current_task] = 1'b1;
				ready_set[current_task]   = 1'b0;
			end
			REQ_READY: begin
				if (int'(prio) < NUM_PRIOS) begin
					delayed_set[prio] = 1'b0;
					ready_set[prio]   = 1'b1;
				end
			end
			default: ;
		endcase

		if (ready_set == '0) begin
			res.idle = 1'b1;
			res.pick = current_task;
		end else begin
			for (int i = NUM_PRIOS - 1; i >= 0; i--)
				if (ready_set[i])
					res.pick = prio_idx_t'(i);
			if (lock_level == '0 && res.pick != current_task) begin
				res.sw       = 1'b1;
				current_task = res.pick;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Sends one request word, with an occasional idle burst first, and records its result.
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [TASK_W-1:0] prio,
			input logic [DTICK_W-1:0] dly);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		task_prio   <= prio;
		delay_ticks <= dly;
		do @(posedge clk); while (!in_ready);
		expected_words.push_back(schedule_step(req, prio, dly));
	endtask

	// Stops sending and waits until every expected result word has arrived.
	task automatic finish_outstanding();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Lock count writes happen only with the block idle.
	task automatic write_lock(input logic [LOCK_W-1:0] value);
		finish_outstanding();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		lock_level = value;
	endtask

	// Mostly short delays so tasks wake within the run, with zero and huge ones mixed in.
	function automatic logic [DTICK_W-1:0] random_delay();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return DTICK_W'($urandom);
			2:       return DTICK_W'(DELAY_MAX);
			default: return DTICK_W'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic send_random_request();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 8)
			send_request(REQ_TICK, TASK_W'($urandom), DTICK_W'($urandom));
		else if (roll < 13)
			send_request(REQ_DELAY, TASK_W'($urandom), random_delay());
		else if (roll < 19)
			send_request(REQ_READY, TASK_W'($urandom), DTICK_W'($urandom));
		else
			send_request(REQ_SPARE, TASK_W'($urandom), DTICK_W'($urandom));
	endtask

	// Nothing ready after reset, and the spare request code only reschedules.
	task automatic test_empty_and_spare();
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_SPARE, '1, '1);
	endtask

	// Zero and maximum delays, re-delay of a delayed task, waking a delayed task.
	task automatic test_delays_and_picks();
		send_request(REQ_DELAY, '0, '0);
		send_request(REQ_TICK, '1, 32'h5A5A_A5A5);
		send_request(REQ_READY, 5'd31, '0);
		send_request(REQ_DELAY, '0, 32'hFFFF_FFFF);
		send_request(REQ_DELAY, '0, 32'd3);
		send_request(REQ_DELAY, '0, 32'd2);
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_READY, 5'd0, '1);
		send_request(REQ_READY, 5'd16, '0);
	endtask

	// A nonzero lock count holds the running task while the pick still moves.
	task automatic test_lock_extremes();
		write_lock(8'd1);
		send_request(REQ_DELAY, '0, 32'd5);
		send_request(REQ_DELAY, '0, 32'd1);
		send_request(REQ_TICK, '0, '0);
		write_lock(8'd255);
		send_request(REQ_READY, 5'd2, '0);
		send_request(REQ_DELAY, '0, 32'd1);
		send_request(REQ_TICK, '0, '0);
		write_lock(8'd0);
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_DELAY, '0, 32'h8000_0000);
		send_request(REQ_READY, 5'd0, '0);
	endtask

	task automatic test_random_traffic(input int unsigned count);
		repeat (count) send_random_request();
	endtask

	// The sender waits for every result word between short bursts.
	task automatic test_drain_between_bursts();
		repeat (6) begin
			repeat ($urandom_range(3, 12)) send_random_request();
			finish_outstanding();
		end
	endtask

	// Main sequence of tests.
	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		req_type    <= REQ_TICK;
		task_prio   <= '0;
		delay_ticks <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_spare();
		test_delays_and_picks();
		test_lock_extremes();
		test_random_traffic(140);
		write_lock(LOCK_W'($urandom_range(2, 254)));
		test_random_traffic(60);
		write_lock(8'd0);
		test_drain_between_bursts();
		test_random_traffic(60);
		write_lock(8'd0);
		idling_on = 1'b0;
		test_random_traffic(90);

		finish_outstanding();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Takes result words at the receiver and drives its random stall bursts.
	initial begin : result_checker
		int unsigned stall_left;
		sched_word_t want;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("result word with none expected, next_task %0d",
						next_task));
				end else begin
					want = expected_words.pop_front();
					if (next_task !== want.pick)
						report_mismatch($sformatf("next_task %0d, expected %0d",
							next_task, want.pick));
					if (do_switch !== want.sw)
						report_mismatch($sformatf("do_switch %b, expected %b",
							do_switch, want.sw));
					if (none_ready !== want.idle)
						report_mismatch($sformatf("none_ready %b, expected %b",
							none_ready, want.idle));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= arst_n;
			end
		end
	end

	// Ends a run that hangs.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule
